// File: design/pwbs_pkg.sv
// ----------------------------------------------------------------------------
// pwbs_pkg: shared definitions for the pulse width bus slave
// Widths, pulse classification windows, slot positions and register indexes.
// ----------------------------------------------------------------------------
package pwbs_pkg;

  // Field and register widths.
  localparam int unsigned OWN_ADDR_W  = 7;
  localparam int unsigned DEV_ID_W    = 8;
  localparam int unsigned FRAME_LEN_W = 5;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned TDATA_W     = 8;

  // Internal state widths.
  localparam int unsigned TICK_W  = 8;   // low tick counter and stored symbols
  localparam int unsigned SLOT_W  = 5;   // slot index, wraps at 32
  localparam int unsigned ADDR_W  = 14;  // widest OR of shifted address symbols
  localparam int unsigned CMD_W   = 12;  // widest OR of shifted command symbols
  localparam int unsigned ENUM_W  = 8;

  // Reset values of the configuration registers.
  localparam logic [OWN_ADDR_W-1:0]  OWN_ADDR_RST  = 7'b0000001;
  localparam logic [DEV_ID_W-1:0]    DEV_ID_RST    = 8'd0;
  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RST = 5'd23;

  // Pulse classification windows, exclusive bounds on the low tick count.
  localparam logic [TICK_W-1:0] ZERO_LO  = 8'd8;
  localparam logic [TICK_W-1:0] ZERO_HI  = 8'd11;
  localparam logic [TICK_W-1:0] ONE_LO   = 8'd17;
  localparam logic [TICK_W-1:0] ONE_HI   = 8'd21;
  localparam logic [TICK_W-1:0] START_LO = 8'd26;
  localparam logic [TICK_W-1:0] START_HI = 8'd35;

  // Symbol codes stored per slot.
  localparam logic [TICK_W-1:0] SYM_ZERO  = 8'd0;
  localparam logic [TICK_W-1:0] SYM_ONE   = 8'd1;
  localparam logic [TICK_W-1:0] SYM_START = 8'd2;

  // Slot positions inside a frame.
  localparam int unsigned SLOT_FIRST_KEPT = 1;   // lowest slot that is ever read
  localparam int unsigned SLOT_ENUM_FLAG  = 1;
  localparam int unsigned SLOT_ADDR_FIRST = 2;
  localparam int unsigned SLOT_ADDR_LAST  = 8;
  localparam int unsigned SLOT_CMD_FIRST  = 9;
  localparam int unsigned SLOT_CMD_LAST   = 13;
  localparam int unsigned SLOT_ID_FIRST   = 14;
  localparam int unsigned SLOT_ID_LAST    = 21;
  localparam int unsigned SLOT_ACK_END    = 22;
  localparam int unsigned SLOT_MIN_END    = 2;   // shortest frame that ends by length

  // Command that asks the slave for its device identifier.
  localparam logic [CMD_W-1:0] CMD_READ_ID = 12'd3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_ADDR  = 2'd0,
    REG_DEVICE_ID = 2'd1,
    REG_FRAME_LEN = 2'd2
  } cfg_reg_t;

endpackage

// File: design/pulse_width_bus_slave.sv
// ----------------------------------------------------------------------------
// pulse_width_bus_slave: single-wire bus slave driven by per-tick line samples
// Classifies low pulses into symbols, decodes address and command slots and
// drives acknowledge, device identifier and enumeration answers.
// ----------------------------------------------------------------------------
// Each input item is one sample of the bus line (and of the inhibit pin) taken
// at one tick; each input item produces exactly one result item giving the
// line driver state and the frame-done flag after that tick. The block takes
// one item per clock cycle: the whole tick update is a single pass of short
// logic from the state registers into the state and result registers, and a
// new item is accepted whenever the result register is empty or its item is
// being taken in the same cycle, and the result is offered in the cycle after
// acceptance. While the line is low the slave counts ticks; on the rising
// edge the pulse becomes symbol 0 (9-10 ticks), 1 (18-20 ticks), start
// (27-34 ticks, restarts the frame) or otherwise the raw tick count.
// Only slots 1 to 13 are ever looked at again, so only those are kept.
// Configuration registers must be written only while no item is in flight.
// ----------------------------------------------------------------------------
module pulse_width_bus_slave
  import pwbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  // Input samples.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,    // [0] line_level, [1] inhibit, rest zero

  // Results.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,   // [0] drive_line, [1] frame_done, rest zero

  // Configuration writes.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [OWN_ADDR_W-1:0]  own_addr_r;
  logic [DEV_ID_W-1:0]    dev_id_r;
  logic [FRAME_LEN_W-1:0] frame_len_r;

  // Tick state.
  logic [TICK_W-1:0] low_ticks_r,  low_ticks_nxt;
  logic [SLOT_W-1:0] slot_idx_r,   slot_idx_nxt;
  logic [TICK_W-1:0] sym_r   [SLOT_FIRST_KEPT:SLOT_CMD_LAST];
  logic [TICK_W-1:0] sym_nxt [SLOT_FIRST_KEPT:SLOT_CMD_LAST];
  logic [ADDR_W-1:0] frame_addr_r, frame_addr_nxt;
  logic [CMD_W-1:0]  cmd_r,        cmd_nxt;
  logic [ENUM_W-1:0] enum_cnt_r,   enum_cnt_nxt;
  logic              rise_seen_r,  rise_seen_nxt;
  logic              fall_seen_r,  fall_seen_nxt;
  logic              drive_r,      drive_nxt;
  logic              frame_flag_r, frame_flag_nxt;

  // Result register.
  logic               out_valid_r;
  logic [TDATA_W-1:0] out_data_r;

  // Working values of the tick update.
  logic              in_acc;
  logic              line_hi;
  logic              line_lo;
  logic [TICK_W-1:0] sym_val;
  logic [SLOT_W-1:0] rise_slot;
  logic [ADDR_W-1:0] addr_bits;
  logic [CMD_W-1:0]  cmd_bits;
  logic              addr_match;
  logic [2:0]        id_bit_sel;

  // The result register frees up in the same cycle its item is taken.
  assign in_tready  = ~out_valid_r | out_tready;
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Inhibit masks both levels, so no edge is seen and nothing is counted.
  assign line_hi = in_tdata[0] & ~in_tdata[1];
  assign line_lo = ~in_tdata[0] & ~in_tdata[1];

  always_comb begin
    low_ticks_nxt  = low_ticks_r;
    slot_idx_nxt   = slot_idx_r;
    sym_nxt        = sym_r;
    frame_addr_nxt = frame_addr_r;
    cmd_nxt        = cmd_r;
    enum_cnt_nxt   = enum_cnt_r;
    rise_seen_nxt  = rise_seen_r;
    fall_seen_nxt  = fall_seen_r;
    drive_nxt      = drive_r;
    frame_flag_nxt = frame_flag_r;
    sym_val        = low_ticks_r;
    rise_slot      = slot_idx_r;
    addr_bits      = '0;
    cmd_bits       = '0;
    addr_match     = 1'b0;
    id_bit_sel     = 3'(5'(SLOT_ID_LAST) - slot_idx_r);

    if (in_acc) begin
      // Rising edge: classify the pulse and act on the slot it fills.
      if (line_hi && !rise_seen_r) begin
        priority if (low_ticks_r > ZERO_LO && low_ticks_r < ZERO_HI) begin
          sym_val = SYM_ZERO;
        end else if (low_ticks_r > ONE_LO && low_ticks_r < ONE_HI) begin
          sym_val = SYM_ONE;
        end else if (low_ticks_r > START_LO && low_ticks_r < START_HI) begin
          // A start symbol opens a new frame at slot zero.
          sym_val        = SYM_START;
          rise_slot      = '0;
          frame_flag_nxt = 1'b0;
          frame_addr_nxt = '0;
          cmd_nxt        = '0;
        end else begin
          sym_val = low_ticks_r;
        end

        for (int i = SLOT_FIRST_KEPT; i <= SLOT_CMD_LAST; i++) begin
          if (rise_slot == SLOT_W'(i)) begin
            sym_nxt[i] = sym_val;
          end
        end

        // Address and command are the OR of the shifted slot symbols,
        // which may be wider than one bit each.
        for (int i = SLOT_ADDR_FIRST; i <= SLOT_ADDR_LAST; i++) begin
          addr_bits = addr_bits | (ADDR_W'(sym_nxt[i]) << (SLOT_ADDR_LAST - i));
        end
        for (int i = SLOT_CMD_FIRST; i <= SLOT_CMD_LAST; i++) begin
          cmd_bits = cmd_bits | (CMD_W'(sym_nxt[i]) << (SLOT_CMD_LAST - i));
        end

        if (rise_slot == SLOT_W'(SLOT_ADDR_LAST)) begin
          frame_addr_nxt = frame_addr_nxt | addr_bits;
          // A broadcast address restarts enumeration.
          if ((frame_addr_nxt | addr_bits) == '0) begin
            enum_cnt_nxt = '0;
          end
        end
        if (rise_slot == SLOT_W'(SLOT_CMD_LAST)) begin
          cmd_nxt = cmd_nxt | cmd_bits;
        end

        addr_match = (frame_addr_nxt == ADDR_W'(own_addr_r));
        if (addr_match && (rise_slot == SLOT_W'(SLOT_CMD_FIRST) ||
                           rise_slot == SLOT_W'(SLOT_CMD_LAST) ||
                           rise_slot == SLOT_W'(SLOT_ACK_END))) begin
          drive_nxt = 1'b1;
        end
        // Device identifier, most significant bit in the first ID slot.
        id_bit_sel = 3'(5'(SLOT_ID_LAST) - rise_slot);
        if (addr_match && cmd_nxt == CMD_READ_ID &&
            rise_slot >= SLOT_W'(SLOT_ID_FIRST) && rise_slot <= SLOT_W'(SLOT_ID_LAST)) begin
          drive_nxt = dev_id_r[id_bit_sel];
        end

        rise_seen_nxt = 1'b1;
        fall_seen_nxt = 1'b0;
        low_ticks_nxt = '0;

        // Enumeration call: symbol one then zero, answered when the running
        // count reaches this slave's address.
        if (sym_nxt[SLOT_ENUM_FLAG] == SYM_ONE && sym_nxt[SLOT_ADDR_FIRST] == SYM_ZERO &&
            rise_slot == SLOT_W'(SLOT_ADDR_FIRST)) begin
          enum_cnt_nxt = enum_cnt_r + 1'b1;
          if (enum_cnt_nxt == ENUM_W'(own_addr_r)) begin
            frame_addr_nxt = ADDR_W'(enum_cnt_nxt);
            drive_nxt      = 1'b1;
          end
        end

        slot_idx_nxt = rise_slot + 1'b1;
      end

      // Falling edge releases the line and clears the frame-done flag.
      if (line_lo && !fall_seen_r) begin
        drive_nxt      = 1'b0;
        fall_seen_nxt  = 1'b1;
        rise_seen_nxt  = 1'b0;
        frame_flag_nxt = 1'b0;
      end
      // The falling-edge tick itself is counted as low.
      if (line_lo) begin
        low_ticks_nxt = low_ticks_r + 1'b1;
      end

      // Frame end by length, checked on every tick.
      if (slot_idx_nxt >= SLOT_W'(SLOT_MIN_END) &&
          slot_idx_nxt == SLOT_W'(frame_len_r)) begin
        slot_idx_nxt   = '0;
        frame_flag_nxt = 1'b1;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r  <= OWN_ADDR_RST;
      dev_id_r    <= DEV_ID_RST;
      frame_len_r <= FRAME_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_OWN_ADDR:  own_addr_r  <= cfg_wdata[OWN_ADDR_W-1:0];
        REG_DEVICE_ID: dev_id_r    <= cfg_wdata[DEV_ID_W-1:0];
        REG_FRAME_LEN: frame_len_r <= cfg_wdata[FRAME_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Tick state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_ticks_r  <= '0;
      slot_idx_r   <= '0;
      frame_addr_r <= '0;
      cmd_r        <= '0;
      enum_cnt_r   <= '0;
      rise_seen_r  <= 1'b0;
      fall_seen_r  <= 1'b0;
      drive_r      <= 1'b0;
      frame_flag_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = SLOT_FIRST_KEPT; i <= SLOT_CMD_LAST; i++) begin
        sym_r[i] <= '0;
      end
    end else begin
      low_ticks_r  <= low_ticks_nxt;
      slot_idx_r   <= slot_idx_nxt;
      sym_r        <= sym_nxt;
      frame_addr_r <= frame_addr_nxt;
      cmd_r        <= cmd_nxt;
      enum_cnt_r   <= enum_cnt_nxt;
      rise_seen_r  <= rise_seen_nxt;
      fall_seen_r  <= fall_seen_nxt;
      drive_r      <= drive_nxt;
      frame_flag_r <= frame_flag_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {(TDATA_W-2)'(0), frame_flag_nxt, drive_nxt};
    end
  end

  // The edge trackers are never both set.
  a_edge_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(rise_seen_r && fall_seen_r))
    else $error("rise and fall trackers both set");

  // Low ticks are only counted after a falling edge.
  a_low_after_fall: assert property (@(posedge clk) disable iff (!rst_n)
    (low_ticks_r != '0) |-> fall_seen_r)
    else $error("low ticks counted without a falling edge");

  // An inhibited sample leaves the low counter alone.
  a_inhibit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tdata[1]) |=> (low_ticks_r == $past(low_ticks_r)))
    else $error("low counter moved under inhibit");

  // A rising edge clears the low counter.
  a_rise_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && line_hi && !rise_seen_r) |=> (low_ticks_r == '0))
    else $error("low counter not cleared on rising edge");

endmodule

// File: tb/pwbs_line_checker.sv
// ----------------------------------------------------------------------------
// pwbs_line_checker: result predictor and comparator for the bus slave
// Watches the sample, result and register ports, keeps its own model of the
// slave and compares every result item field by field with its prediction.
// ----------------------------------------------------------------------------
module pwbs_line_checker
  import pwbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,    // [0] line_level, [1] inhibit, rest zero
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [TDATA_W-1:0]    out_tdata,   // [0] drive_line, [1] frame_done, rest zero
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    checked,
  output int                    drive_highs,
  output int                    frame_ends
);

  typedef struct packed {
    logic frame_done;
    logic drive_line;
  } line_result_t;

  // Register copies.
  logic [OWN_ADDR_W-1:0]  own_addr;
  logic [DEV_ID_W-1:0]    dev_id;
  logic [FRAME_LEN_W-1:0] frame_len;

  // Slave state.
  logic [TICK_W-1:0] low_cnt;
  logic [SLOT_W-1:0] slot;
  logic [TICK_W-1:0] symbols [32];
  logic [15:0]       addr_acc;
  logic [15:0]       cmd_acc;
  logic [ENUM_W-1:0] enum_cnt;
  logic              rose;
  logic              fell;
  logic              driver;
  logic              frame_end;

  line_result_t line_result_q[$];

  task automatic clear_model();
    own_addr  = OWN_ADDR_RST;
    dev_id    = DEV_ID_RST;
    frame_len = FRAME_LEN_RST;
    low_cnt   = '0;
    slot      = '0;
    foreach (symbols[i]) symbols[i] = '0;
    addr_acc  = '0;
    cmd_acc   = '0;
    enum_cnt  = '0;
    rose      = 1'b0;
    fell      = 1'b0;
    driver    = 1'b0;
    frame_end = 1'b0;
  endtask

  // Rising edge: turn the low count into a symbol, store it and act on it.
  task automatic classify_rise();
    logic [TICK_W-1:0] code;
    logic [15:0]       word;
    logic              hit;
    int                i;
    code = low_cnt;
    if (code > ZERO_LO && code < ZERO_HI) begin
      code = SYM_ZERO;
    end else if (code > ONE_LO && code < ONE_HI) begin
      code = SYM_ONE;
    end else if (code > START_LO && code < START_HI) begin
      code      = SYM_START;
      slot      = '0;
      frame_end = 1'b0;
      addr_acc  = '0;
      cmd_acc   = '0;
    end
    symbols[slot] = code;

    if (slot == SLOT_ADDR_LAST) begin
      word = '0;
      for (i = SLOT_ADDR_FIRST; i <= SLOT_ADDR_LAST; i++)
        word = word | (16'(symbols[i]) << (SLOT_ADDR_LAST - i));
      addr_acc = addr_acc | word;
      if (addr_acc == '0) enum_cnt = '0;
    end
    if (slot == SLOT_CMD_LAST) begin
      word = '0;
      for (i = SLOT_CMD_FIRST; i <= SLOT_CMD_LAST; i++)
        word = word | (16'(symbols[i]) << (SLOT_CMD_LAST - i));
      cmd_acc = cmd_acc | word;
    end

    // Acknowledge slots, then the identifier bits, MSB first.
    hit = (addr_acc == 16'(own_addr));
    if (hit && (slot == SLOT_CMD_FIRST || slot == SLOT_CMD_LAST || slot == SLOT_ACK_END))
      driver = 1'b1;
    if (hit && cmd_acc == 16'(CMD_READ_ID) && slot >= SLOT_ID_FIRST && slot <= SLOT_ID_LAST)
      driver = dev_id[SLOT_ID_LAST - slot];

    rose    = 1'b1;
    fell    = 1'b0;
    low_cnt = '0;

    if (symbols[SLOT_ENUM_FLAG] == SYM_ONE && symbols[SLOT_ADDR_FIRST] == SYM_ZERO &&
        slot == SLOT_ADDR_FIRST) begin
      enum_cnt = enum_cnt + 1'b1;
      if (enum_cnt == {1'b0, own_addr}) begin
        addr_acc = 16'(enum_cnt);
        driver   = 1'b1;
      end
    end
    slot = slot + 1'b1;
  endtask

  task automatic advance_bus_model(input logic line, input logic inh,
                                   output line_result_t res);
    logic high;
    logic low;
    high = line && !inh;
    low  = !line && !inh;
    if (high && !rose) classify_rise();
    if (low && !fell) begin
      driver    = 1'b0;
      fell      = 1'b1;
      rose      = 1'b0;
      frame_end = 1'b0;
    end
    if (low && fell) low_cnt = low_cnt + 1'b1;
    if (slot >= SLOT_MIN_END && slot == frame_len) begin
      slot      = '0;
      frame_end = 1'b1;
    end
    res.drive_line = driver;
    res.frame_done = frame_end;
  endtask

  task automatic report_fault(input string what, input int want, input int got);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // Everything is sampled at the falling edge, after the stimulus moved
  // and before the transfers take effect.
  always @(negedge clk) begin : watch
    line_result_t want;
    line_result_t got;
    if (!rst_n) begin
      clear_model();
      line_result_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_OWN_ADDR:  own_addr  = cfg_wdata[OWN_ADDR_W-1:0];
          REG_DEVICE_ID: dev_id    = cfg_wdata[DEV_ID_W-1:0];
          REG_FRAME_LEN: frame_len = cfg_wdata[FRAME_LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        advance_bus_model(in_tdata[0], in_tdata[1], want);
        line_result_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[1:0];
        checked++;
        if (line_result_q.size() == 0) begin
          report_fault("result with no sample pending", -1, int'(got));
        end else begin
          want = line_result_q.pop_front();
          if (got.drive_line !== want.drive_line)
            report_fault("drive_line", want.drive_line, got.drive_line);
          if (got.frame_done !== want.frame_done)
            report_fault("frame_done", want.frame_done, got.frame_done);
          if (out_tdata[TDATA_W-1:2] !== '0)
            report_fault("tdata padding", 0, int'(out_tdata[TDATA_W-1:2]));
          if (got.drive_line === 1'b1) drive_highs++;
          if (got.frame_done === 1'b1) frame_ends++;
        end
      end
    end
    pending = line_result_q.size();
  end

endmodule

// File: tb/pulse_width_bus_slave_test.sv
// ----------------------------------------------------------------------------
// pulse_width_bus_slave_test: top level testbench of the pulse width bus slave
// Feeds line samples shaped into symbols and frames, idles both stream sides
// at random, steps through several register settings and hands checking to a
// separate checker; prints the verdict at the end.
// ----------------------------------------------------------------------------
module pulse_width_bus_slave_test;
  import pwbs_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int IDLE_PCT      = 35;      // chance of an idle cycle on either side
  localparam int HOLD_CYCLES   = 64;      // one long hold-off on the result side
  localparam int RANDOM_BUDGET = 100;     // samples of random traffic per setting
  localparam int CALM_BUDGET   = 100;     // samples sent with no random idling
  localparam int CYCLE_LIMIT   = 200000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [TDATA_W-1:0]    in_tdata   = '0;    // [0] line_level, [1] inhibit, rest zero
  logic                  out_tready = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr   = REG_OWN_ADDR;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [TDATA_W-1:0]    out_tdata;          // [0] drive_line, [1] frame_done, rest zero

  // While calm is set neither side idles at random. It is always changed
  // with a nonblocking assignment, so the result side sees it only at a later edge.
  bit                    calm       = 1'b0;
  bit                    hold_done  = 1'b0;
  int                    hold_left  = 0;
  int                    cycle_count  = 0;
  int                    samples_sent = 0;
  int                    settings_used = 1;
  // Address the random frames aim at most of the time.
  logic [OWN_ADDR_W-1:0] aim_addr   = OWN_ADDR_RST;

  int fail_count;
  int pending;
  int checked;
  int drive_highs;
  int frame_ends;

  pulse_width_bus_slave u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  pwbs_line_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .drive_highs (drive_highs),
    .frame_ends  (frame_ends)
  );

  always #CLK_HALF clk = ~clk;

  // Result side. It stalls at random, except during the calm stretch. The
  // first time calm is seen it holds off for a long stretch of its own while
  // the sender keeps offering samples, so the result register fills and the
  // slave has to stall its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (calm && !hold_done) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count, pending);
      $display("** pulse_width_bus_slave: FAILED **");
      $finish;
    end
  end

  // Offers one line sample and returns at the edge where it was taken.
  // The ready is sampled at the falling edge, where it has settled.
  task automatic send_sample(input logic line, input logic inh);
    logic taken;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(TDATA_W-2){1'b0}}, inh, line};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    samples_sent++;
  endtask

  task automatic send_run(input logic line, input int count);
    repeat (count) send_sample(line, 1'b0);
  endtask

  // A low pulse of the given length followed by a short high gap.
  task automatic send_pulse(input int lows);
    send_run(1'b0, lows);
    send_run(1'b1, ($urandom_range(3) == 0) ? $urandom_range(4, 2) : 1);
  endtask

  // A well formed symbol with a length picked anywhere inside its window.
  task automatic send_symbol(input logic [TICK_W-1:0] code);
    case (code)
      SYM_ZERO: send_pulse($urandom_range(ZERO_HI - 1, ZERO_LO + 1));
      SYM_ONE:  send_pulse($urandom_range(ONE_HI - 1, ONE_LO + 1));
      default:  send_pulse($urandom_range(START_HI - 1, START_LO + 1));
    endcase
  endtask

  // A pulse that falls outside every window, so its raw count is stored.
  task automatic send_raw();
    case ($urandom_range(3))
      0:       send_pulse($urandom_range(ZERO_LO, 1));
      1:       send_pulse($urandom_range(ONE_LO, ZERO_HI));
      2:       send_pulse($urandom_range(START_LO, ONE_HI));
      default: send_pulse($urandom_range(60, START_HI));
    endcase
  endtask

  // A frame: start, enumeration flag, address bits MSB first, command bits,
  // then identifier and acknowledge slots. Most frames address the slave
  // and many ask for its identifier; a few carry stray raw pulses or stop
  // early or run past the frame end.
  task automatic send_frame();
    logic [OWN_ADDR_W-1:0] addr;
    logic [4:0]            cmd;
    logic                  enum_call;
    int                    last_slot;
    int                    s;
    addr      = ($urandom_range(99) < 60) ? aim_addr : OWN_ADDR_W'($urandom);
    cmd       = ($urandom_range(99) < 50) ? 5'(CMD_READ_ID) : 5'($urandom);
    enum_call = ($urandom_range(99) < 25);
    // An enumeration call needs a zero in the first address slot.
    if (enum_call) addr[OWN_ADDR_W-1] = 1'b0;
    last_slot = ($urandom_range(99) < 70) ? SLOT_ACK_END : $urandom_range(26, 1);
    send_symbol(SYM_START);
    for (s = 1; s <= last_slot; s++) begin
      if ($urandom_range(99) < 4)
        send_raw();
      else if (s == SLOT_ENUM_FLAG)
        send_symbol(enum_call ? SYM_ONE : SYM_ZERO);
      else if (s <= SLOT_ADDR_LAST)
        send_symbol(addr[SLOT_ADDR_LAST - s] ? SYM_ONE : SYM_ZERO);
      else if (s <= SLOT_CMD_LAST)
        send_symbol(cmd[SLOT_CMD_LAST - s] ? SYM_ONE : SYM_ZERO);
      else
        send_symbol($urandom_range(1) ? SYM_ONE : SYM_ZERO);
    end
  endtask

  // Noise: a burst of pulses of 1 to 40 low samples, with inhibit samples
  // mixed in on both line levels. Short pulses also walk the slot index around.
  task automatic send_noise();
    int n;
    int lows;
    n = $urandom_range(8, 2);
    repeat (n) begin
      lows = $urandom_range(40, 1);
      repeat (lows) send_sample(1'b0, $urandom_range(99) < 8);
      repeat ($urandom_range(3, 1)) send_sample(1'b1, $urandom_range(99) < 15);
    end
  endtask

  task automatic run_random(input int budget);
    int stop;
    stop = samples_sent + budget;
    while (samples_sent < stop) begin
      if ($urandom_range(99) < 75) send_frame();
      else send_noise();
    end
  endtask

  // Writes all three registers on back to back cycles, enable held high.
  task automatic program_regs(input logic [OWN_ADDR_W-1:0] addr,
                              input logic [DEV_ID_W-1:0] id,
                              input logic [FRAME_LEN_W-1:0] len);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_OWN_ADDR;
    cfg_wdata <= CFG_DATA_W'(addr);
    @(posedge clk);
    cfg_addr  <= REG_DEVICE_ID;
    cfg_wdata <= CFG_DATA_W'(id);
    @(posedge clk);
    cfg_addr  <= REG_FRAME_LEN;
    cfg_wdata <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_we    <= 1'b0;
    aim_addr  = addr;
    settings_used++;
  endtask

  // Stops offering and waits until every predicted result has come back,
  // then waits on so the slave is idle before registers change.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int window_edges [12];
    window_edges = '{8, 9, 10, 11, 17, 18, 20, 21, 26, 27, 34, 35};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset register values. The line starts high,
    // so the first sample is already a rising edge with a zero low count.
    send_run(1'b1, 3);
    // Inhibit on both line levels.
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);
    // A start pulse with inhibit in the middle: the count pauses, so two
    // stretches of fifteen low samples still add up to a start.
    send_run(1'b0, 15);
    repeat (5) send_sample(1'b0, 1'b1);
    send_run(1'b0, 15);
    send_run(1'b1, 2);
    // Both sides of every classification window.
    foreach (window_edges[i]) send_pulse(window_edges[i]);
    // A low pulse long enough to wrap the tick counter back into the zero
    // window.
    send_pulse(265);

    run_random(RANDOM_BUDGET);
    drain();

    // Highest values, with the calm stretch and the long result hold-off.
    program_regs('1, '1, '1);
    calm <= 1'b1;
    run_random(CALM_BUDGET);
    calm <= 1'b0;
    drain();

    // Address zero and the shortest frame that still ends by length.
    program_regs('0, DEV_ID_W'($urandom), FRAME_LEN_W'(SLOT_MIN_END));
    run_random(RANDOM_BUDGET);
    drain();

    // Frame length below the minimum: frames never end, slots only wrap.
    program_regs(OWN_ADDR_W'($urandom), DEV_ID_W'($urandom),
                 FRAME_LEN_W'($urandom_range(1, 0)));
    run_random(RANDOM_BUDGET);
    drain();

    $display("Sent %0d line samples under %0d register settings, with one long output hold-off.",
             samples_sent, settings_used);
    $display("Checked %0d results: driver on in %0d of them, frame end flagged in %0d.",
             checked, drive_highs, frame_ends);
    if (fail_count == 0) begin
      $display("** pulse_width_bus_slave: PASSED **");
    end else begin
      $display("%0d mismatches in total.", fail_count);
      $display("** pulse_width_bus_slave: FAILED **");
    end
    $finish;
  end

endmodule

// File: pulse_width_bus_slave.f
design/pwbs_pkg.sv
design/pulse_width_bus_slave.sv
tb/pwbs_line_checker.sv
tb/pulse_width_bus_slave_test.sv
